FILE: hw/rtl/sef_pkg.sv
package sef_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_ADAPTIVE      = 3'd1,
    CFG_ATTACK        = 3'd2,
    CFG_RELEASE       = 3'd3,
    CFG_FAST_RELEASE  = 3'd4
  } cfg_reg_t;

endpackage

FILE: hw/rtl/stereo_envelope_follower.sv
// Stereo envelope follower. Each transaction on the in_ channel carries one stereo pair; the
// block returns one envelope level on the out_ channel, saturated to 0..2^(SAMPLE_BITS-1).
// All multiplies go through one shift-add unit that retires one coefficient bit per cycle, and
// the relative-drop ratio comes from a restoring divider that makes one quotient bit per cycle,
// so the time from acceptance to a valid result is set by COEF_BITS. The attack and fixed-release
// cases take one pass through the multiplier; adaptive release takes up to three passes (square,
// coefficient, envelope) plus the division. A new pair is taken once the previous
// result has been placed in the output register; in_stall is high while a pair is in work.
// Configuration writes must be made only while the block is idle.
module stereo_envelope_follower
  import sef_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS)-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_left_sample,
  input  logic [SAMPLE_BITS-1:0] in_right_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_envelope_level
);

  localparam int S     = SAMPLE_BITS;
  localparam int C     = COEF_BITS;
  localparam int XW    = (S > C + 1) ? S : C + 1;
  localparam int PW    = XW + C + 3;
  localparam int RW    = XW + 3;
  localparam int CNT_W = $clog2(C + 2);

  localparam logic [C:0]       M_ONE  = {1'b1, {C{1'b0}}};
  localparam logic [PW-1:0]    P_HALF = {{(PW-C){1'b0}}, 1'b1, {(C-1){1'b0}}};
  localparam logic [RW-1:0]    R_ONE  = {{(RW-C-1){1'b0}}, 1'b1, {C{1'b0}}};
  localparam logic [RW-1:0]    R_CMAX = {{(RW-C){1'b0}}, {C{1'b1}}};
  localparam logic [RW-1:0]    R_EMAX = {{(RW-S){1'b0}}, 1'b1, {(S-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(C);

  typedef enum logic [3:0] {
    S_IDLE, S_PEAK, S_LEVEL, S_SEL, S_DIV, S_SQ, S_MUL, S_ROUND, S_POST, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_SQ, PH_COEF, PH_ENV
  } phase_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [S-1:0]    thr_r, thr_nxt;
  logic            adapt_r, adapt_nxt;
  logic [C-1:0]    att_r, att_nxt;
  logic [C-1:0]    rel_r, rel_nxt;
  logic [C-1:0]    fast_r, fast_nxt;
  logic [S-1:0]    env_r, env_nxt;
  logic [S-1:0]    left_r, left_nxt;
  logic [S-1:0]    right_r, right_nxt;
  logic [S-1:0]    peak_r, peak_nxt;
  logic [S-1:0]    level_r, level_nxt;
  logic [S:0]      rem_r, rem_nxt;
  logic [C:0]      q_r, q_nxt;
  logic [C:0]      m1_r, m1_nxt;
  logic [C:0]      m2_r, m2_nxt;
  logic [XW-1:0]   x1_r, x1_nxt;
  logic [XW-1:0]   x2_r, x2_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [RW-1:0]   rnd_r, rnd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [S-1:0]    out_env_r, out_env_nxt;

  logic [S-1:0]    mag_left, mag_right;
  logic [S:0]      div_sh;
  logic            div_bit;
  logic [XW+1:0]   mul_sum;
  logic [C:0]      r2_c;
  logic [C-1:0]    coef_c;
  logic [S-1:0]    env_c;

  assign mag_left  = left_r[S-1]  ? ({S{1'b0}} - left_r)  : left_r;
  assign mag_right = right_r[S-1] ? ({S{1'b0}} - right_r) : right_r;
  assign div_sh  = (cnt_r == '0) ? rem_r : {rem_r[S-1:0], 1'b0};
  assign div_bit = div_sh >= (S+1)'(env_r);
  assign mul_sum = p_r[PW-1 -: XW+2]
                 + (m1_r[0] ? (XW+2)'(x1_r) : '0)
                 + (m2_r[0] ? (XW+2)'(x2_r) : '0);
  assign r2_c    = (rnd_r > R_ONE)  ? R_ONE[C:0]    : rnd_r[C:0];
  assign coef_c  = (rnd_r > R_CMAX) ? R_CMAX[C-1:0] : rnd_r[C-1:0];
  assign env_c   = (rnd_r > R_EMAX) ? R_EMAX[S-1:0] : rnd_r[S-1:0];

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_envelope_level = out_env_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    thr_nxt       = thr_r;
    adapt_nxt     = adapt_r;
    att_nxt       = att_r;
    rel_nxt       = rel_r;
    fast_nxt      = fast_r;
    env_nxt       = env_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    peak_nxt      = peak_r;
    level_nxt     = level_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    p_nxt         = p_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_env_nxt   = out_env_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD:    thr_nxt   = cfg_data[S-1:0];
        CFG_ADAPTIVE:     adapt_nxt = cfg_data[0];
        CFG_ATTACK:       att_nxt   = cfg_data[C-1:0];
        CFG_RELEASE:      rel_nxt   = cfg_data[C-1:0];
        CFG_FAST_RELEASE: fast_nxt  = cfg_data[C-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          left_nxt  = in_left_sample;
          right_nxt = in_right_sample;
          state_nxt = S_PEAK;
        end
      end
      S_PEAK: begin
        peak_nxt  = (mag_left > mag_right) ? mag_left : mag_right;
        state_nxt = S_LEVEL;
      end
      S_LEVEL: begin
        level_nxt = (peak_r > thr_r) ? (peak_r - thr_r) : '0;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if ((level_r > env_r) || !adapt_r) begin
          m1_nxt    = (C+1)'((level_r > env_r) ? att_r : rel_r);
          m2_nxt    = M_ONE - (C+1)'((level_r > env_r) ? att_r : rel_r);
          x1_nxt    = XW'(env_r);
          x2_nxt    = XW'(level_r);
          p_nxt     = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_ENV;
          state_nxt = S_MUL;
        end else if (env_r == '0) begin
          q_nxt     = '0;
          state_nxt = S_SQ;
        end else begin
          rem_nxt   = (S+1)'(env_r - level_r);
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_bit ? (div_sh - (S+1)'(env_r)) : div_sh;
        q_nxt   = {q_r[C-1:0], div_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        m1_nxt    = q_r;
        m2_nxt    = '0;
        x1_nxt    = XW'(q_r);
        x2_nxt    = '0;
        p_nxt     = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_SQ;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt   = {1'b0, mul_sum, p_r[C:1]};
        m1_nxt  = m1_r >> 1;
        m2_nxt  = m2_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        rnd_nxt   = RW'((p_r + P_HALF) >> C);
        state_nxt = S_POST;
      end
      S_POST: begin
        case (phase_r)
          PH_SQ: begin
            m1_nxt    = M_ONE - r2_c;
            m2_nxt    = r2_c;
            x1_nxt    = XW'(rel_r);
            x2_nxt    = XW'(fast_r);
            p_nxt     = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_COEF;
            state_nxt = S_MUL;
          end
          PH_COEF: begin
            m1_nxt    = (C+1)'(coef_c);
            m2_nxt    = M_ONE - (C+1)'(coef_c);
            x1_nxt    = XW'(env_r);
            x2_nxt    = XW'(level_r);
            p_nxt     = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_ENV;
            state_nxt = S_MUL;
          end
          PH_ENV: begin
            env_nxt   = env_c;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_env_nxt   = env_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    peak_r    <= peak_nxt;
    level_r   <= level_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    m1_r      <= m1_nxt;
    m2_r      <= m2_nxt;
    x1_r      <= x1_nxt;
    x2_r      <= x2_nxt;
    p_r       <= p_nxt;
    rnd_r     <= rnd_nxt;
    cnt_r     <= cnt_nxt;
    phase_r   <= phase_nxt;
    out_env_r <= out_env_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= '0;
      adapt_r     <= 1'b0;
      att_r       <= '0;
      rel_r       <= '0;
      fast_r      <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      adapt_r     <= adapt_nxt;
      att_r       <= att_nxt;
      rel_r       <= rel_nxt;
      fast_r      <= fast_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/sef_checker.sv
module sef_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] out_envelope_level
);

  localparam logic [SAMPLE_BITS-1:0] ENV_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // held result must not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_envelope_level))
    else $error("result changed while stalled");

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_envelope_level <= ENV_MAX)
    else $error("envelope above full scale");

  // one pair in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second pair taken while busy");

  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared straight after acceptance");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear handshake");

endmodule

bind stereo_envelope_follower sef_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sef_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_envelope_level (out_envelope_level)
);
